/* sv/rqob_pkg.sv */
package rqob_pkg;

  // Field widths fixed by the interface
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 9;
  localparam int LIMIT_W = 7;
  localparam int SPILL_W = 32;

  // Configuration port
  localparam int          ADDR_W       = 3;
  localparam int          DATA_W       = 32;
  localparam logic        REG_CAPACITY = 1'b0;
  localparam logic [8:0]  CAP_RESET    = 9'd256;

  typedef enum logic [1:0] {
    MODE_PUSH      = 2'd0,
    MODE_POP       = 2'd1,
    MODE_POP_MATCH = 2'd2,
    MODE_BATCH     = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                mode;
    logic [VALUE_W-1:0]   entry_value;
    logic                 drop_new_when_full;
    logic [LIMIT_W-1:0]   batch_limit;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   out_entry;
    logic                 out_valid;
    logic                 last_of_run;
    logic                 push_accepted;
    logic                 evicted_oldest;
    logic [CAP_W-1:0]     occupancy;
    logic [SPILL_W-1:0]   spill_total;
    logic [VALUE_W-1:0]   head_entry;
    logic [VALUE_W-1:0]   tail_entry;
  } result_t;

endpackage

/* sv/rqob_ram.sv */
module rqob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ring_queue_overwrite_batch_pop.sv */
// Ring queue of entry handles with programmable capacity, overwrite-oldest
// pushes and three kinds of pop. A request is taken when start is high and
// busy is low. Each result appears on result for exactly one cycle with
// result_strobe high; the receiver cannot stall it, so it must take every
// strobed result. A push or pop goes from S_EXEC to the registered result,
// and through S_FILL as well when the new head has to be fetched from the
// slot memory (a pop that leaves entries behind, or a push that evicts the
// oldest entry while more than one slot is in use); the registered read of
// the slot memory is why S_FILL is needed. A batch pop emits its first
// result on the same terms, then one result per further S_EXEC and S_FILL
// pass, with a final result that empties the queue coming straight from
// S_EXEC; the last one is marked by last_of_run. busy drops in the cycle in
// which the final result of a request is strobed, so the next request can
// be taken then. Writing capacity_in_use empties the queue and keeps the
// spill count; write it only while the block is idle.
module ring_queue_overwrite_batch_pop #(
  parameter int DEPTH       = 256,
  parameter int ENTRY_WIDTH = 32,
  parameter int MAX_BATCH   = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  // request channel
  input  logic                     start,
  input  rqob_pkg::item_t          item,
  output logic                     busy,
  // result channel
  output logic                     result_strobe,
  output rqob_pkg::result_t        result,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [rqob_pkg::ADDR_W-1:0] paddr,
  input  logic [rqob_pkg::DATA_W-1:0] pwdata,
  output logic [rqob_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);

  import rqob_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = ENTRY_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FILL} state_t;

  // Clamp a capacity value to 1..DEPTH
  function automatic logic [CAP_W-1:0] eff_of(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CAP_W'(1);
    end else if (32'(c) > 32'(DEPTH)) begin
      r = CAP_W'(DEPTH);
    end
    return r;
  endfunction

  // Step an index around the ring
  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx,
                                        input logic [CAP_W-1:0] cap);
    logic [31:0] n;
    n = 32'(idx) + 32'd1;
    return (n >= 32'(cap)) ? '0 : AW'(n);
  endfunction

  // Assemble a result; head and tail read as zero when empty
  function automatic result_t mk(input logic [EW-1:0] e, input logic v,
                                 input logic l, input logic a, input logic x,
                                 input logic [CAP_W-1:0] cnt,
                                 input logic [SPILL_W-1:0] sp,
                                 input logic [EW-1:0] hv,
                                 input logic [EW-1:0] tv);
    result_t r;
    r.out_entry      = VALUE_W'(e);
    r.out_valid      = v;
    r.last_of_run    = l;
    r.push_accepted  = a;
    r.evicted_oldest = x;
    r.occupancy      = cnt;
    r.spill_total    = sp;
    r.head_entry     = (cnt == '0) ? '0 : VALUE_W'(hv);
    r.tail_entry     = (cnt == '0) ? '0 : VALUE_W'(tv);
    return r;
  endfunction

  state_t               state, state_next;
  item_t                req, req_next;
  logic [AW-1:0]        head_index, head_index_next;
  logic [AW-1:0]        tail_index, tail_index_next;
  logic [CAP_W-1:0]     count, count_next;
  logic [SPILL_W-1:0]   spill, spill_next;
  logic [CAP_W-1:0]     cap_reg, cap_reg_next;
  logic [EW-1:0]        head_val, head_val_next;
  logic [EW-1:0]        tail_val, tail_val_next;
  logic [LIMIT_W-1:0]   batch_n, batch_n_next;
  result_t              rsp_next, pend, pend_next;
  logic                 strobe_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;

  logic [CAP_W-1:0]     eff_cap, new_cap;
  logic                 full;
  logic [AW-1:0]        head_adv, tail_adv;
  logic [EW-1:0]        val_e;
  logic [LIMIT_W-1:0]   lim_eff;
  logic [CAP_W-1:0]     cnt_dec;
  logic                 last;
  logic                 cfg_wr;

  rqob_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Derived views of the current state
  assign eff_cap  = eff_of(cap_reg);
  assign full     = count >= eff_cap;
  assign head_adv = adv(head_index, eff_cap);
  assign tail_adv = adv(tail_index, eff_cap);
  assign val_e    = EW'(req.entry_value);
  assign lim_eff  = (req.batch_limit == '0 || req.batch_limit > LIMIT_W'(MAX_BATCH)) ?
                    LIMIT_W'(MAX_BATCH) : req.batch_limit;
  assign cnt_dec  = count - CAP_W'(1);
  assign last     = (req.mode != MODE_BATCH) || (cnt_dec == '0) ||
                    (batch_n + LIMIT_W'(1) == lim_eff);

  // Always fetch the slot behind the head; used only on the way to S_FILL
  assign ram_raddr = head_adv;
  assign ram_waddr = tail_adv;
  assign ram_wdata = val_e;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready &&
                   (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign new_cap = eff_of(pwdata[CAP_W-1:0]);
  assign prdata  = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? DATA_W'(cap_reg) : '0;

  assign busy = (state != S_IDLE);

  // Sequence one request: execute, optionally refill the head, emit, and loop for a batch pop
  always_comb begin
    state_next      = state;
    req_next        = req;
    head_index_next = head_index;
    tail_index_next = tail_index;
    count_next      = count;
    spill_next      = spill;
    cap_reg_next    = cap_reg;
    head_val_next   = head_val;
    tail_val_next   = tail_val;
    batch_n_next    = batch_n;
    pend_next       = pend;
    rsp_next        = result;
    strobe_next     = 1'b0;
    ram_we          = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next     = item;
          batch_n_next = '0;
          state_next   = S_EXEC;
        end
        // reprogram capacity and empty the queue
        if (cfg_wr) begin
          cap_reg_next    = pwdata[CAP_W-1:0];
          head_index_next = '0;
          tail_index_next = AW'(new_cap - CAP_W'(1));
          count_next      = '0;
        end
      end

      S_EXEC: begin
        if (req.mode == MODE_PUSH) begin
          if (full && req.drop_new_when_full) begin
            // drop the push, report unchanged state
            rsp_next    = mk('0, 1'b0, 1'b1, 1'b0, 1'b0, count, spill, head_val, tail_val);
            strobe_next = 1'b1;
            state_next  = S_IDLE;
          end else begin
            ram_we          = 1'b1;
            tail_index_next = tail_adv;
            tail_val_next   = val_e;
            if (full) begin
              // evict the oldest entry
              spill_next      = spill + SPILL_W'(1);
              head_index_next = head_adv;
              if (head_adv == tail_adv) begin
                head_val_next = val_e;
                rsp_next      = mk('0, 1'b0, 1'b1, 1'b1, 1'b1, count,
                                   spill + SPILL_W'(1), val_e, val_e);
                strobe_next   = 1'b1;
                state_next    = S_IDLE;
              end else begin
                pend_next  = mk('0, 1'b0, 1'b1, 1'b1, 1'b1, count,
                                spill + SPILL_W'(1), head_val, val_e);
                state_next = S_FILL;
              end
            end else begin
              count_next = count + CAP_W'(1);
              if (count == '0) begin
                head_val_next = val_e;
              end
              rsp_next    = mk('0, 1'b0, 1'b1, 1'b1, 1'b0, count + CAP_W'(1), spill,
                               (count == '0) ? val_e : head_val, val_e);
              strobe_next = 1'b1;
              state_next  = S_IDLE;
            end
          end
        end else if (count == '0 ||
                     (req.mode == MODE_POP_MATCH && head_val != val_e)) begin
          // nothing to remove
          rsp_next    = mk('0, 1'b0, 1'b1, 1'b0, 1'b0, count, spill, head_val, tail_val);
          strobe_next = 1'b1;
          state_next  = S_IDLE;
        end else begin
          // remove the head
          head_index_next = head_adv;
          count_next      = cnt_dec;
          batch_n_next    = batch_n + LIMIT_W'(1);
          if (cnt_dec == '0) begin
            rsp_next    = mk(head_val, 1'b1, 1'b1, 1'b0, 1'b0, cnt_dec, spill,
                             head_val, tail_val);
            strobe_next = 1'b1;
            state_next  = S_IDLE;
          end else begin
            pend_next  = mk(head_val, 1'b1, last, 1'b0, 1'b0, cnt_dec, spill,
                            head_val, tail_val);
            state_next = S_FILL;
          end
        end
      end

      S_FILL: begin
        // load the new head from memory and emit
        head_val_next       = ram_rdata;
        rsp_next            = pend;
        rsp_next.head_entry = VALUE_W'(ram_rdata);
        strobe_next         = 1'b1;
        state_next          = pend.last_of_run ? S_IDLE : S_EXEC;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head_index    <= '0;
      tail_index    <= AW'(eff_of(CAP_RESET) - CAP_W'(1));
      count         <= '0;
      spill         <= '0;
      cap_reg       <= CAP_RESET;
      batch_n       <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      head_index    <= head_index_next;
      tail_index    <= tail_index_next;
      count         <= count_next;
      spill         <= spill_next;
      cap_reg       <= cap_reg_next;
      batch_n       <= batch_n_next;
      result_strobe <= strobe_next;
    end
    req      <= req_next;
    head_val <= head_val_next;
    tail_val <= tail_val_next;
    pend     <= pend_next;
    result   <= rsp_next;
  end

  // Occupancy never exceeds the capacity in force
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> result.occupancy <= eff_cap)
    else $error("occupancy above capacity");

  // A head refill must not read the slot being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_EXEC && state_next == S_FILL) |-> ram_waddr != ram_raddr)
    else $error("head refill reads slot under write");

  // Batch never runs past its limit
  a_batch_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> batch_n <= lim_eff)
    else $error("batch count beyond limit");

  // An eviction only happens on a stored push
  a_evict_push: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.evicted_oldest) |-> result.push_accepted)
    else $error("eviction without stored push");

  // A result never both removes and stores an entry
  a_pop_push_excl: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !(result.out_valid && result.push_accepted))
    else $error("result both popped and pushed");

endmodule
